// File: sv/vcm_pkg.sv
// Shared types, codes and constants for the change maker core.
// Used by vcm_front, vcm_coin_cell and vending_change_maker_core; no dependencies.
package vcm_pkg;

    localparam int STOCK_BITS_DEF = 16;
    localparam int FIELD_W = 16;
    localparam int AMT_W = 17;
    localparam int DUE_W = 18;

    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_DEPOSIT = 2'd1;
    localparam logic [1:0] MODE_CANCEL = 2'd2;

    localparam logic [2:0] KIND_NICKEL = 3'd0;
    localparam logic [2:0] KIND_DIME = 3'd1;
    localparam logic [2:0] KIND_QUARTER = 3'd2;
    localparam logic [2:0] KIND_ONE = 3'd3;
    localparam logic [2:0] KIND_FIVE = 3'd4;

    localparam logic [2:0] ST_PRICE_OK = 3'd0;
    localparam logic [2:0] ST_PRICE_ILLEGAL = 3'd1;
    localparam logic [2:0] ST_PENDING = 3'd2;
    localparam logic [2:0] ST_ILLEGAL_SEL = 3'd3;
    localparam logic [2:0] ST_CHANGE_GIVEN = 3'd4;
    localparam logic [2:0] ST_OUT_OF_CHANGE = 3'd5;
    localparam logic [2:0] ST_WRONG_PHASE = 3'd6;

    // coin cell index equals the deposit kind code of that coin
    localparam int COIN_NICKEL = 0;
    localparam int COIN_DIME = 1;
    localparam int COIN_QUARTER = 2;

    localparam int unsigned STOCK_RESET [5] = '{25, 25, 25, 0, 0};

    // floor(x / coin) = (x * RECIP) >> SHIFT, exact for x < 2^17
    localparam logic [17:0] COIN_RECIP [3] = '{18'd104858, 18'd104858, 18'd167773};
    localparam int COIN_SHIFT [3] = '{19, 20, 22};

    // floor(x / 5) = (x * MOD5_RECIP) >> MOD5_SHIFT, exact for x < 2^16
    localparam logic [15:0] MOD5_RECIP = 16'd52429;
    localparam int MOD5_SHIFT = 18;

    typedef struct packed {
        logic [2:0]                  status;
        logic                        refund;
        logic [AMT_W-1:0]            amount;
        logic                        dep_valid;
        logic [2:0]                  dep_kind;
        logic [FIELD_W-1:0]          amount_due;
        logic [2:0][FIELD_W-1:0]     give;
        logic [4:0][FIELD_W-1:0]     stock;
    } vcm_beat_t;

    function automatic logic [9:0] denom_value(input logic [2:0] kind);
        logic [9:0] val;
        unique case (kind)
            KIND_NICKEL:  val = 10'd5;
            KIND_DIME:    val = 10'd10;
            KIND_QUARTER: val = 10'd25;
            KIND_ONE:     val = 10'd100;
            KIND_FIVE:    val = 10'd500;
            default:      val = 10'd0;
        endcase
        return val;
    endfunction

    function automatic logic [AMT_W-1:0] coin_times(input logic [1:0] coin,
                                                     input logic [AMT_W-1:0] cnt);
        logic [AMT_W-1:0] val;
        unique case (coin)
            2'd0:    val = (cnt << 2) + cnt;
            2'd1:    val = (cnt << 3) + (cnt << 1);
            2'd2:    val = (cnt << 4) + (cnt << 3) + cnt;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

// File: sv/vcm_front.sv
// Front cell: purchase phase, amount due, price, bill stocks and refund decision.
// Depends on vcm_pkg.
module vcm_front #(
    parameter int STOCK_BITS = vcm_pkg::STOCK_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [1:0]                         mode,
    input  logic [vcm_pkg::FIELD_W-1:0]        price_cents,
    input  logic [2:0]                         deposit_kind,
    output logic                               out_valid,
    input  logic                               out_stall,
    output vcm_pkg::vcm_beat_t                 out_beat
);

    localparam int CW = (STOCK_BITS > vcm_pkg::FIELD_W) ? STOCK_BITS : vcm_pkg::FIELD_W;
    localparam logic [STOCK_BITS-1:0] STOCK_MAX = '1;

    logic                                   valid_reg;
    vcm_pkg::vcm_beat_t                     beat_reg, beat_next;
    logic                                   active_reg, active_next;
    logic signed [vcm_pkg::DUE_W-1:0]       due_reg, due_next;
    logic [vcm_pkg::FIELD_W-1:0]            start_reg, start_next;
    logic [STOCK_BITS-1:0]                  one_reg, one_next;
    logic [STOCK_BITS-1:0]                  five_reg, five_next;

    logic                                   advance;
    logic                                   accept;
    logic [31:0]                            price_prod;
    logic [vcm_pkg::FIELD_W-1:0]            price_q5;
    logic [vcm_pkg::FIELD_W-1:0]            price_rem;
    logic signed [vcm_pkg::DUE_W-1:0]       due_dep;
    logic signed [vcm_pkg::DUE_W-1:0]       due_neg;
    logic signed [vcm_pkg::DUE_W-1:0]       cancel_diff;
    logic [2:0]                             status;
    logic                                   refund;
    logic [vcm_pkg::AMT_W-1:0]              amount;
    logic                                   dep_valid;
    logic [CW-1:0]                          one_ext;
    logic [CW-1:0]                          five_ext;

    assign advance = !valid_reg || !out_stall;
    assign accept = in_valid && advance;
    assign in_stall = !advance;

    assign price_prod = {16'd0, price_cents} * {16'd0, vcm_pkg::MOD5_RECIP};
    assign price_q5 = vcm_pkg::FIELD_W'(price_prod >> vcm_pkg::MOD5_SHIFT);
    assign price_rem = price_cents - ((price_q5 << 2) + price_q5);

    assign due_dep = due_reg - $signed({8'd0, vcm_pkg::denom_value(deposit_kind)});
    assign due_neg = -due_dep;
    assign cancel_diff = $signed({2'b00, start_reg}) - due_reg;

    always_comb
    begin
        active_next = active_reg;
        due_next = due_reg;
        start_next = start_reg;
        one_next = one_reg;
        five_next = five_reg;
        status = vcm_pkg::ST_ILLEGAL_SEL;
        refund = 1'b0;
        amount = '0;
        dep_valid = 1'b0;
        unique case (mode)
            vcm_pkg::MODE_START:
            begin
                if (active_reg)
                begin
                    status = vcm_pkg::ST_WRONG_PHASE;
                end
                else if (price_rem != '0)
                begin
                    status = vcm_pkg::ST_PRICE_ILLEGAL;
                end
                else
                begin
                    status = vcm_pkg::ST_PRICE_OK;
                    active_next = 1'b1;
                    start_next = price_cents;
                    due_next = $signed({2'b00, price_cents});
                end
            end
            vcm_pkg::MODE_DEPOSIT:
            begin
                if (!active_reg)
                begin
                    status = vcm_pkg::ST_WRONG_PHASE;
                end
                else if (deposit_kind > vcm_pkg::KIND_FIVE)
                begin
                    status = vcm_pkg::ST_ILLEGAL_SEL;
                end
                else
                begin
                    status = vcm_pkg::ST_PENDING;
                    dep_valid = 1'b1;
                    due_next = due_dep;
                    if (deposit_kind == vcm_pkg::KIND_ONE && one_reg != STOCK_MAX)
                    begin
                        one_next = one_reg + 1'b1;
                    end
                    if (deposit_kind == vcm_pkg::KIND_FIVE && five_reg != STOCK_MAX)
                    begin
                        five_next = five_reg + 1'b1;
                    end
                    if (due_dep <= 0)
                    begin
                        refund = 1'b1;
                        amount = due_neg[vcm_pkg::AMT_W-1:0];
                        active_next = 1'b0;
                        due_next = '0;
                    end
                end
            end
            vcm_pkg::MODE_CANCEL:
            begin
                if (!active_reg)
                begin
                    status = vcm_pkg::ST_WRONG_PHASE;
                end
                else
                begin
                    status = vcm_pkg::ST_PENDING;
                    refund = 1'b1;
                    amount = cancel_diff[vcm_pkg::AMT_W-1:0];
                    active_next = 1'b0;
                    due_next = '0;
                end
            end
            default:
            begin
                status = vcm_pkg::ST_ILLEGAL_SEL;
            end
        endcase
    end

    assign one_ext = CW'(one_next);
    assign five_ext = CW'(five_next);

    always_comb
    begin
        beat_next = '0;
        beat_next.status = status;
        beat_next.refund = refund;
        beat_next.amount = amount;
        beat_next.dep_valid = dep_valid;
        beat_next.dep_kind = deposit_kind;
        beat_next.amount_due = active_next ? due_next[vcm_pkg::FIELD_W-1:0] : '0;
        beat_next.stock[vcm_pkg::KIND_ONE] = one_ext[vcm_pkg::FIELD_W-1:0];
        beat_next.stock[vcm_pkg::KIND_FIVE] = five_ext[vcm_pkg::FIELD_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            active_reg <= 1'b0;
            due_reg <= '0;
            start_reg <= '0;
            one_reg <= STOCK_BITS'(vcm_pkg::STOCK_RESET[3]);
            five_reg <= STOCK_BITS'(vcm_pkg::STOCK_RESET[4]);
        end
        else
        begin
            if (advance)
            begin
                valid_reg <= in_valid;
            end
            if (accept)
            begin
                active_reg <= active_next;
                due_reg <= due_next;
                start_reg <= start_next;
                one_reg <= one_next;
                five_reg <= five_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            beat_reg <= beat_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_beat = beat_reg;

endmodule

// File: sv/vcm_coin_cell.sv
// Coin cell: holds one coin stock, adds deposits of that coin, pays its share of change.
// Depends on vcm_pkg.
module vcm_coin_cell #(
    parameter int STOCK_BITS = vcm_pkg::STOCK_BITS_DEF,
    parameter int COIN = vcm_pkg::COIN_QUARTER
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  vcm_pkg::vcm_beat_t   in_beat,
    output logic                 out_valid,
    input  logic                 out_stall,
    output vcm_pkg::vcm_beat_t   out_beat
);

    localparam int CW = (STOCK_BITS > vcm_pkg::FIELD_W) ? STOCK_BITS : vcm_pkg::FIELD_W;
    localparam logic [17:0] RECIP = vcm_pkg::COIN_RECIP[COIN];
    localparam int SHIFT = vcm_pkg::COIN_SHIFT[COIN];
    localparam logic [2:0] KIND = 3'(COIN);
    localparam logic [STOCK_BITS-1:0] STOCK_MAX = '1;

    logic                           valid_reg;
    vcm_pkg::vcm_beat_t             beat_reg, beat_next;
    logic [STOCK_BITS-1:0]          stock_reg, stock_next;

    logic                           advance;
    logic                           accept;
    logic [STOCK_BITS-1:0]          stock_inc;
    logic [34:0]                    product;
    logic [vcm_pkg::FIELD_W-1:0]    want;
    logic [CW-1:0]                  want_ext;
    logic [CW-1:0]                  stock_ext;
    logic [CW-1:0]                  cnt_ext;
    logic [CW-1:0]                  left_ext;
    logic [vcm_pkg::FIELD_W-1:0]    cnt;
    logic [vcm_pkg::AMT_W-1:0]      paid;

    assign advance = !valid_reg || !out_stall;
    assign accept = in_valid && advance;
    assign in_stall = !advance;

    assign stock_inc = (in_beat.dep_valid && in_beat.dep_kind == KIND && stock_reg != STOCK_MAX)
                       ? stock_reg + 1'b1 : stock_reg;

    assign product = {18'd0, in_beat.amount} * {17'd0, RECIP};
    assign want = vcm_pkg::FIELD_W'(product >> SHIFT);
    assign want_ext = CW'(want);
    assign stock_ext = CW'(stock_inc);
    assign cnt_ext = (want_ext < stock_ext) ? want_ext : stock_ext;
    assign cnt = cnt_ext[vcm_pkg::FIELD_W-1:0];
    assign paid = vcm_pkg::coin_times(2'(COIN), vcm_pkg::AMT_W'(cnt));
    assign left_ext = stock_ext - cnt_ext;
    assign stock_next = left_ext[STOCK_BITS-1:0];

    always_comb
    begin
        beat_next = in_beat;
        beat_next.amount = in_beat.amount - paid;
        beat_next.give[COIN] = cnt;
        beat_next.stock[COIN] = left_ext[vcm_pkg::FIELD_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            stock_reg <= STOCK_BITS'(vcm_pkg::STOCK_RESET[COIN]);
        end
        else
        begin
            if (advance)
            begin
                valid_reg <= in_valid;
            end
            if (accept)
            begin
                stock_reg <= stock_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            beat_reg <= beat_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_beat = beat_reg;

endmodule

// File: sv/vending_change_maker_core.sv
// Change maker core: front cell followed by quarter, dime and nickel cells.
// Depends on vcm_pkg, vcm_front and vcm_coin_cell.
//
//   channel   handshake                  payload
//   item      item_valid / item_stall    mode, price_cents, deposit_kind
//   result    result_valid / result_stall status, amount_due, give_*, shortfall_cents, stock_*
//
// One item per cycle sustained while result_stall stays low; each result is registered
// once in each of the four cells (front, quarter, dime, nickel).
// Each cell owns its part of the state, so consecutive items never wait on each other.
// Reset is asynchronous: stocks return to 25, 25, 25, 0, 0 and the machine goes idle.
// A stalled result holds the chain; empty cells still take new items.
module vending_change_maker_core #(
    parameter int STOCK_BITS = vcm_pkg::STOCK_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             item_valid,
    output logic                             item_stall,
    input  logic [1:0]                       mode,
    input  logic [vcm_pkg::FIELD_W-1:0]      price_cents,
    input  logic [2:0]                       deposit_kind,
    output logic                             result_valid,
    input  logic                             result_stall,
    output logic [2:0]                       status,
    output logic [vcm_pkg::FIELD_W-1:0]      amount_due,
    output logic [vcm_pkg::FIELD_W-1:0]      give_quarters,
    output logic [vcm_pkg::FIELD_W-1:0]      give_dimes,
    output logic [vcm_pkg::FIELD_W-1:0]      give_nickels,
    output logic [vcm_pkg::AMT_W-1:0]        shortfall_cents,
    output logic [vcm_pkg::FIELD_W-1:0]      stock_nickel,
    output logic [vcm_pkg::FIELD_W-1:0]      stock_dime,
    output logic [vcm_pkg::FIELD_W-1:0]      stock_quarter,
    output logic [vcm_pkg::FIELD_W-1:0]      stock_one,
    output logic [vcm_pkg::FIELD_W-1:0]      stock_five
);

    logic                  front_valid, front_stall;
    vcm_pkg::vcm_beat_t    front_beat;
    logic                  qtr_valid, qtr_stall;
    vcm_pkg::vcm_beat_t    qtr_beat;
    logic                  dime_valid, dime_stall;
    vcm_pkg::vcm_beat_t    dime_beat;
    vcm_pkg::vcm_beat_t    last_beat;

    vcm_front #(
        .STOCK_BITS (STOCK_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (item_valid),
        .in_stall     (item_stall),
        .mode         (mode),
        .price_cents  (price_cents),
        .deposit_kind (deposit_kind),
        .out_valid    (front_valid),
        .out_stall    (front_stall),
        .out_beat     (front_beat)
    );

    vcm_coin_cell #(
        .STOCK_BITS (STOCK_BITS),
        .COIN       (vcm_pkg::COIN_QUARTER)
    ) u_quarter (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_stall  (front_stall),
        .in_beat   (front_beat),
        .out_valid (qtr_valid),
        .out_stall (qtr_stall),
        .out_beat  (qtr_beat)
    );

    vcm_coin_cell #(
        .STOCK_BITS (STOCK_BITS),
        .COIN       (vcm_pkg::COIN_DIME)
    ) u_dime (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (qtr_valid),
        .in_stall  (qtr_stall),
        .in_beat   (qtr_beat),
        .out_valid (dime_valid),
        .out_stall (dime_stall),
        .out_beat  (dime_beat)
    );

    vcm_coin_cell #(
        .STOCK_BITS (STOCK_BITS),
        .COIN       (vcm_pkg::COIN_NICKEL)
    ) u_nickel (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dime_valid),
        .in_stall  (dime_stall),
        .in_beat   (dime_beat),
        .out_valid (result_valid),
        .out_stall (result_stall),
        .out_beat  (last_beat)
    );

    always_comb
    begin
        if (!last_beat.refund)
        begin
            status = last_beat.status;
        end
        else if (last_beat.amount != '0)
        begin
            status = vcm_pkg::ST_OUT_OF_CHANGE;
        end
        else
        begin
            status = vcm_pkg::ST_CHANGE_GIVEN;
        end
    end

    assign amount_due = last_beat.amount_due;
    assign give_quarters = last_beat.give[vcm_pkg::COIN_QUARTER];
    assign give_dimes = last_beat.give[vcm_pkg::COIN_DIME];
    assign give_nickels = last_beat.give[vcm_pkg::COIN_NICKEL];
    assign shortfall_cents = last_beat.amount;
    assign stock_nickel = last_beat.stock[vcm_pkg::KIND_NICKEL];
    assign stock_dime = last_beat.stock[vcm_pkg::KIND_DIME];
    assign stock_quarter = last_beat.stock[vcm_pkg::KIND_QUARTER];
    assign stock_one = last_beat.stock[vcm_pkg::KIND_ONE];
    assign stock_five = last_beat.stock[vcm_pkg::KIND_FIVE];

`ifndef SYNTH
    a_short_means_out: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && shortfall_cents != '0) |-> (status == vcm_pkg::ST_OUT_OF_CHANGE))
        else $error("shortfall reported without out-of-change status");

    a_coins_only_on_refund: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && status != vcm_pkg::ST_CHANGE_GIVEN
                      && status != vcm_pkg::ST_OUT_OF_CHANGE)
        |-> (give_quarters == '0 && give_dimes == '0 && give_nickels == '0))
        else $error("coins paid on a beat without refund");

    a_refund_ends_purchase: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (status == vcm_pkg::ST_CHANGE_GIVEN
                      || status == vcm_pkg::ST_OUT_OF_CHANGE))
        |-> (amount_due == '0))
        else $error("amount due left after refund");

    a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (result_valid && result_stall))
        else $error("item stalled while result side is free");
`endif

endmodule

// File: tb/vending_change_checker.sv
`timescale 1ns / 100ps
// Result checker for vending_change_maker_core: predicts every result beat from the
// item beats it sees and compares it against the result channel. Depends on vcm_pkg.
module vending_change_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    input  logic                        item_stall,
    input  logic [1:0]                  mode,
    input  logic [vcm_pkg::FIELD_W-1:0] price_cents,
    input  logic [2:0]                  deposit_kind,
    input  logic                        result_valid,
    input  logic                        result_stall,
    input  logic [2:0]                  status,
    input  logic [vcm_pkg::FIELD_W-1:0] amount_due,
    input  logic [vcm_pkg::FIELD_W-1:0] give_quarters,
    input  logic [vcm_pkg::FIELD_W-1:0] give_dimes,
    input  logic [vcm_pkg::FIELD_W-1:0] give_nickels,
    input  logic [vcm_pkg::AMT_W-1:0]   shortfall_cents,
    input  logic [vcm_pkg::FIELD_W-1:0] stock_nickel,
    input  logic [vcm_pkg::FIELD_W-1:0] stock_dime,
    input  logic [vcm_pkg::FIELD_W-1:0] stock_quarter,
    input  logic [vcm_pkg::FIELD_W-1:0] stock_one,
    input  logic [vcm_pkg::FIELD_W-1:0] stock_five,
    output int                          errors,
    output int                          outstanding
);
    import vcm_pkg::*;

    localparam int DENOM_CENTS [5] = '{5, 10, 25, 100, 500};

    typedef struct packed {
        logic [2:0]              status;
        logic [FIELD_W-1:0]      amount_due;
        logic [FIELD_W-1:0]      give_q;
        logic [FIELD_W-1:0]      give_d;
        logic [FIELD_W-1:0]      give_n;
        logic [AMT_W-1:0]        shortfall;
        logic [4:0][FIELD_W-1:0] stock;
    } change_out_t;

    logic [STOCK_BITS_DEF-1:0] stock_cnt [5];
    bit                        sale_open;
    int                        due_cents;
    logic [FIELD_W-1:0]        sale_price;
    change_out_t               change_q [$];
    int                        fail_count = 0;

    assign errors = fail_count;
    assign outstanding = change_q.size();

    task automatic check_field(input string label, input logic [AMT_W-1:0] want,
                               input logic [AMT_W-1:0] got);
        if (want !== got) begin
            $display("%0t %s: expected %0d, actual %0d", $time, label, want, got);
            fail_count++;
        end
    endtask

    task automatic predict_change(input logic [1:0] m, input logic [FIELD_W-1:0] p,
                                  input logic [2:0] k, output change_out_t r);
        bit refund;
        int refund_amt;
        int want;
        int cnt;
        int c;
        r = '0;
        refund = 1'b0;
        refund_amt = 0;
        case (m)
            MODE_START:
                if (sale_open)
                    r.status = ST_WRONG_PHASE;
                else if (p % 5 != 0)
                    r.status = ST_PRICE_ILLEGAL;
                else
                begin
                    r.status = ST_PRICE_OK;
                    sale_open = 1'b1;
                    sale_price = p;
                    due_cents = int'(p);
                end
            MODE_DEPOSIT:
                if (!sale_open)
                    r.status = ST_WRONG_PHASE;
                else if (k > KIND_FIVE)
                    r.status = ST_ILLEGAL_SEL;
                else
                begin
                    if (stock_cnt[k] != '1)
                        stock_cnt[k]++;
                    due_cents -= DENOM_CENTS[k];
                    if (due_cents <= 0)
                    begin
                        refund = 1'b1;
                        refund_amt = -due_cents;
                    end
                    r.status = ST_PENDING;
                end
            MODE_CANCEL:
                if (!sale_open)
                    r.status = ST_WRONG_PHASE;
                else
                begin
                    refund = 1'b1;
                    refund_amt = int'(sale_price) - due_cents;
                    r.status = ST_PENDING;
                end
            default:
                r.status = ST_ILLEGAL_SEL;
        endcase
        if (refund)
        begin
            for (c = COIN_QUARTER; c >= COIN_NICKEL; c--)
            begin
                want = refund_amt / DENOM_CENTS[c];
                cnt = (want < int'(stock_cnt[c])) ? want : int'(stock_cnt[c]);
                stock_cnt[c] = stock_cnt[c] - STOCK_BITS_DEF'(cnt);
                refund_amt -= cnt * DENOM_CENTS[c];
                if (c == COIN_QUARTER)
                    r.give_q = FIELD_W'(cnt);
                else if (c == COIN_DIME)
                    r.give_d = FIELD_W'(cnt);
                else
                    r.give_n = FIELD_W'(cnt);
            end
            r.shortfall = AMT_W'(refund_amt);
            r.status = (refund_amt != 0) ? ST_OUT_OF_CHANGE : ST_CHANGE_GIVEN;
            sale_open = 1'b0;
            due_cents = 0;
        end
        r.amount_due = sale_open ? FIELD_W'(due_cents) : '0;
        for (c = 0; c < 5; c++)
            r.stock[c] = stock_cnt[c];
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        change_out_t next_out;
        change_out_t want_out;
        if (!rst_n)
        begin
            foreach (stock_cnt[i])
                stock_cnt[i] = STOCK_BITS_DEF'(STOCK_RESET[i]);
            sale_open = 1'b0;
            due_cents = 0;
            sale_price = '0;
            change_q.delete();
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (change_q.size() == 0)
                begin
                    $display("%0t result beat: expected none, actual status %0d",
                             $time, status);
                    fail_count++;
                end
                else
                begin
                    want_out = change_q.pop_front();
                    check_field("status", AMT_W'(want_out.status), AMT_W'(status));
                    check_field("amount_due", AMT_W'(want_out.amount_due),
                                AMT_W'(amount_due));
                    check_field("give_quarters", AMT_W'(want_out.give_q),
                                AMT_W'(give_quarters));
                    check_field("give_dimes", AMT_W'(want_out.give_d), AMT_W'(give_dimes));
                    check_field("give_nickels", AMT_W'(want_out.give_n),
                                AMT_W'(give_nickels));
                    check_field("shortfall_cents", want_out.shortfall, shortfall_cents);
                    check_field("stock_nickel", AMT_W'(want_out.stock[KIND_NICKEL]),
                                AMT_W'(stock_nickel));
                    check_field("stock_dime", AMT_W'(want_out.stock[KIND_DIME]),
                                AMT_W'(stock_dime));
                    check_field("stock_quarter", AMT_W'(want_out.stock[KIND_QUARTER]),
                                AMT_W'(stock_quarter));
                    check_field("stock_one", AMT_W'(want_out.stock[KIND_ONE]),
                                AMT_W'(stock_one));
                    check_field("stock_five", AMT_W'(want_out.stock[KIND_FIVE]),
                                AMT_W'(stock_five));
                end
            end
            if (item_valid && !item_stall)
            begin
                predict_change(mode, price_cents, deposit_kind, next_out);
                change_q.push_back(next_out);
            end
        end
    end

endmodule

// File: tb/vending_change_maker_core_tb.sv
`timescale 1ns / 100ps
// Top of the change maker testbench: clock, reset, item stimulus and verdict.
// Depends on vcm_pkg, vending_change_maker_core and vending_change_checker.
module vending_change_maker_core_tb;
    import vcm_pkg::*;

    localparam logic [1:0] MODE_UNKNOWN = 2'd3;
    localparam logic [2:0] KIND_BAD_FIRST = 3'd5;
    localparam logic [2:0] KIND_BAD_MID = 3'd6;
    localparam logic [2:0] KIND_BAD_LAST = 3'd7;
    localparam int DENOM_CENTS [5] = '{5, 10, 25, 100, 500};
    localparam int CYCLE_LIMIT = 2000000;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 item_valid;
    logic                 item_stall;
    logic [1:0]           mode;
    logic [FIELD_W-1:0]   price_cents;
    logic [2:0]           deposit_kind;
    logic                 result_valid;
    logic                 result_stall = 1'b0;
    logic [2:0]           status;
    logic [FIELD_W-1:0]   amount_due;
    logic [FIELD_W-1:0]   give_quarters;
    logic [FIELD_W-1:0]   give_dimes;
    logic [FIELD_W-1:0]   give_nickels;
    logic [AMT_W-1:0]     shortfall_cents;
    logic [FIELD_W-1:0]   stock_nickel;
    logic [FIELD_W-1:0]   stock_dime;
    logic [FIELD_W-1:0]   stock_quarter;
    logic [FIELD_W-1:0]   stock_one;
    logic [FIELD_W-1:0]   stock_five;

    int fail_total;
    int pending;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int cycle_count = 0;

    vending_change_maker_core uut (.*);

    vending_change_checker chk (
        .*,
        .errors(fail_total),
        .outstanding(pending)
    );

    always #10 clk = ~clk;

    always @(negedge clk)
        result_stall <= ($urandom_range(99) < stall_pct);

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Enter and leave at a falling edge; hold the beat until it is taken.
    task automatic send_item(input logic [1:0] m, input logic [FIELD_W-1:0] p,
                             input logic [2:0] k);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        mode <= m;
        price_cents <= p;
        deposit_kind <= k;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Always ends with the machine idle.
    task automatic random_traffic(input int budget);
        int sent;
        int price;
        int paid;
        int roll;
        bit in_sale;
        logic [2:0] k;
        logic [FIELD_W-1:0] p;
        sent = 0;
        while (sent < budget)
        begin
            if ($urandom_range(99) < 12)
            begin
                p = FIELD_W'($urandom);
                case ($urandom_range(3))
                    0: send_item(MODE_DEPOSIT, p, 3'($urandom));
                    1: send_item(MODE_CANCEL, p, 3'($urandom));
                    2: send_item(MODE_UNKNOWN, p, 3'($urandom));
                    default: send_item(MODE_START, (p % 5 == 0) ? p ^ 16'd1 : p,
                                       3'($urandom));
                endcase
                sent++;
            end
            roll = $urandom_range(99);
            if (roll < 55)
                price = 5 * $urandom_range(40);
            else if (roll < 80)
                price = 5 * $urandom_range(400);
            else
                price = 5 * $urandom_range(13107);
            send_item(MODE_START, FIELD_W'(price), 3'($urandom));
            sent++;
            paid = 0;
            in_sale = 1'b1;
            while (in_sale)
            begin
                roll = $urandom_range(99);
                p = FIELD_W'($urandom);
                if (roll < 5)
                begin
                    send_item(MODE_CANCEL, p, 3'($urandom));
                    in_sale = 1'b0;
                end
                else if (roll < 12)
                begin
                    case (roll % 3)
                        0: send_item(MODE_START, p, 3'($urandom));
                        1: send_item(MODE_DEPOSIT, p,
                                     3'($urandom_range(KIND_BAD_FIRST, KIND_BAD_LAST)));
                        default: send_item(MODE_UNKNOWN, p, 3'($urandom));
                    endcase
                end
                else
                begin
                    k = (price > 1000 && $urandom_range(99) < 70) ? KIND_FIVE
                                                                 : 3'($urandom_range(4));
                    send_item(MODE_DEPOSIT, p, k);
                    paid += DENOM_CENTS[k];
                    in_sale = (paid < price);
                end
                sent++;
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        item_valid = 1'b0;
        mode = MODE_START;
        price_cents = '0;
        deposit_kind = KIND_NICKEL;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 28;
        stall_pct = 63;

        send_item(MODE_DEPOSIT, 16'd0, KIND_NICKEL);
        send_item(MODE_CANCEL, 16'hFFFF, KIND_BAD_LAST);
        send_item(MODE_UNKNOWN, 16'h5555, KIND_FIVE);
        send_item(MODE_START, 16'd7, KIND_NICKEL);
        send_item(MODE_START, 16'hFFFE, KIND_BAD_LAST);
        send_item(MODE_START, 16'd0, KIND_NICKEL);
        send_item(MODE_START, 16'd100, KIND_NICKEL);
        send_item(MODE_DEPOSIT, 16'd0, KIND_BAD_FIRST);
        send_item(MODE_DEPOSIT, 16'hFFFF, KIND_BAD_LAST);
        send_item(MODE_UNKNOWN, 16'hAAAA, KIND_DIME);
        send_item(MODE_DEPOSIT, 16'd0, KIND_FIVE);
        send_item(MODE_START, 16'hFFFF, KIND_BAD_LAST);
        send_item(MODE_DEPOSIT, 16'd0, KIND_ONE);
        send_item(MODE_CANCEL, 16'd0, KIND_NICKEL);
        send_item(MODE_START, 16'd25, KIND_NICKEL);
        send_item(MODE_DEPOSIT, 16'd0, KIND_QUARTER);
        send_item(MODE_START, 16'd0, KIND_NICKEL);
        send_item(MODE_DEPOSIT, 16'd0, KIND_FIVE);
        send_item(MODE_START, 16'd10, KIND_NICKEL);
        send_item(MODE_DEPOSIT, 16'd0, KIND_DIME);
        send_item(MODE_DEPOSIT, 16'd0, KIND_NICKEL);
        send_item(MODE_START, 16'd5, KIND_NICKEL);
        send_item(MODE_DEPOSIT, 16'd0, KIND_BAD_MID);
        send_item(MODE_DEPOSIT, 16'd0, KIND_NICKEL);

        random_traffic(520);

        send_idle_pct = 63;
        stall_pct = 28;
        random_traffic(520);

        send_idle_pct = 0;
        stall_pct = 0;
        random_traffic(260);
        random_traffic(260);

        item_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (fail_total == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
